// ===== sv/spectral_feature_extractor_assert.svh =====
// assertion helpers for the spectral feature extractor
`ifndef SPECTRAL_FEATURE_EXTRACTOR_ASSERT_SVH
`define SPECTRAL_FEATURE_EXTRACTOR_ASSERT_SVH

`define SFE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/sfe_pkg.sv =====
`timescale 1ns / 1ps
package sfe_pkg;
    localparam int MAX_BINS_DEF = 4096;
    localparam int FREQ_W   = 19;
    localparam int MAG_W    = 24;
    localparam int FRAC_W   = 16;
    localparam int ENERGY_W = 60;
    localparam int CFG_W    = 19;
    localparam int IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_ROLL_FRACTION = 2'd0;
    localparam logic [IDX_W-1:0] REG_BAND_LOW      = 2'd1;
    localparam logic [IDX_W-1:0] REG_BAND_HIGH     = 2'd2;

    localparam logic [FRAC_W-1:0] ROLL_FRACTION_RST = 16'd55706;
    localparam logic [FREQ_W-1:0] BAND_LOW_RST      = 19'd0;
    localparam logic [FREQ_W-1:0] BAND_HIGH_RST     = 19'd524287;

    typedef struct packed {
        logic [FREQ_W-1:0] bin_freq;
        logic [MAG_W-1:0]  bin_mag;
        logic              last_bin;
    } bin_t;

    typedef struct packed {
        logic [FREQ_W-1:0]   centroid_freq;
        logic [FREQ_W-1:0]   rolloff_freq;
        logic [FREQ_W-1:0]   dominant_freq;
        logic [ENERGY_W-1:0] band_energy;
        logic                too_few_bins;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic take;       // accumulate the input beat
        logic div_start;  // load divider
        logic div_step;   // one quotient bit
        logic scan_start; // begin rolloff pass
        logic scan_rd;    // issue memory read
        logic scan_acc;   // accumulate read data
        logic emit;       // present result
        logic clear;      // drop accumulators
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic scan_hit;   // running sum reached the target
        logic scan_end;   // read address reached the last stored bin
    } stat_t;
endpackage

// ===== sv/spectral_feature_extractor.sv =====
`timescale 1ns / 1ps
// Bins load one per cycle (a bin beat while busy is low).
// After a last bin: the setup states S_SETTLE and S_LOAD, the divide, then a rolloff pass
// that reads and accumulates each stored bin in turn; done pulses once the pass ends.
// Bins of a new spectrum are not taken while busy is high. Receiver cannot stall.
// Reset (async, active low) clears accumulators and restores register defaults.
module spectral_feature_extractor #(
    parameter int MAX_BINS = sfe_pkg::MAX_BINS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  sfe_pkg::bin_t             bin_in,
    output logic                      done,
    output sfe_pkg::result_t          result,
    input  logic                      cfg_we,
    input  logic [sfe_pkg::IDX_W-1:0] cfg_idx,
    input  logic [sfe_pkg::CFG_W-1:0] cfg_data
);
    import sfe_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    sfe_ctrl u_ctrl (
        .clk, .rst_n, .start, .last_bin(bin_in.last_bin),
        .stat, .cmd, .busy, .done
    );

    sfe_datapath #(.MAX_BINS(MAX_BINS)) u_dp (
        .clk, .rst_n, .bin_in, .cfg_we, .cfg_idx, .cfg_data,
        .cmd, .stat, .result
    );
endmodule

// ===== sv/sfe_datapath.sv =====
`timescale 1ns / 1ps
module sfe_datapath #(
    parameter int MAX_BINS = sfe_pkg::MAX_BINS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sfe_pkg::bin_t               bin_in,
    input  logic                        cfg_we,
    input  logic [sfe_pkg::IDX_W-1:0]   cfg_idx,
    input  logic [sfe_pkg::CFG_W-1:0]   cfg_data,
    input  sfe_pkg::cmd_t               cmd,
    output sfe_pkg::stat_t              stat,
    output sfe_pkg::result_t            result
);
    import sfe_pkg::*;

    localparam int AW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CW   = $clog2(MAX_BINS + 1);
    localparam int TOTW = MAG_W + CW;
    localparam int WW   = TOTW + FREQ_W;
    localparam int PW   = 2 * MAG_W;
    localparam int TW   = TOTW + FRAC_W;
    localparam int QW   = FREQ_W;
    localparam int DCW  = $clog2(QW + 1);

    logic [FRAC_W-1:0]  roll_fraction_reg;
    logic [FREQ_W-1:0]  band_low_reg, band_high_reg;

    logic [MAG_W-1:0]   mag_mem [MAX_BINS];
    logic [FREQ_W-1:0]  freq_mem [MAX_BINS];

    logic [CW-1:0]      bin_count_reg;
    logic [TOTW-1:0]    mag_total_reg;
    logic [WW-1:0]      weighted_reg;
    logic [ENERGY_W-1:0] band_power_reg;
    logic [MAG_W-1:0]   peak_mag_reg;
    logic [FREQ_W-1:0]  peak_freq_reg;

    // product stage
    logic               p_vld_reg, p_inb_reg;
    logic [PW-1:0]      p_sq_reg;
    logic [MAG_W+FREQ_W-1:0] p_mf_reg;

    // divider
    logic [WW-1:0]      rem_reg;
    logic [QW-1:0]      quo_reg;
    logic [DCW-1:0]     dcnt_reg;

    // scan
    logic [AW-1:0]      raddr_reg;
    logic [MAG_W-1:0]   rmag_reg;
    logic [FREQ_W-1:0]  rfreq_reg;
    logic [TOTW-1:0]    run_reg;
    logic [TW-1:0]      target_reg;
    logic [FREQ_W-1:0]  roll_reg;
    logic               found_reg;

    logic full;
    logic [AW-1:0] waddr;
    logic [AW-1:0] last_addr;
    logic [TOTW-1:0] run_next;

    assign full      = bin_count_reg >= CW'(MAX_BINS);
    assign waddr     = bin_count_reg[AW-1:0];
    assign last_addr = AW'(bin_count_reg - CW'(1));
    assign run_next  = run_reg + TOTW'(rmag_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_fraction_reg <= ROLL_FRACTION_RST;
            band_low_reg      <= BAND_LOW_RST;
            band_high_reg     <= BAND_HIGH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_ROLL_FRACTION: roll_fraction_reg <= cfg_data[FRAC_W-1:0];
                REG_BAND_LOW:      band_low_reg      <= cfg_data[FREQ_W-1:0];
                REG_BAND_HIGH:     band_high_reg     <= cfg_data[FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && !full)
        begin
            mag_mem[waddr]  <= bin_in.bin_mag;
            freq_mem[waddr] <= bin_in.bin_freq;
        end
        if (cmd.scan_rd)
        begin
            rmag_reg  <= mag_mem[raddr_reg];
            rfreq_reg <= freq_mem[raddr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg  <= '0;
            mag_total_reg  <= '0;
            weighted_reg   <= '0;
            band_power_reg <= '0;
            peak_mag_reg   <= '0;
            peak_freq_reg  <= '0;
            p_vld_reg      <= 1'b0;
        end
        else
        begin
            p_vld_reg <= cmd.take && !full;
            if (cmd.take && !full)
            begin
                bin_count_reg <= bin_count_reg + CW'(1);
                mag_total_reg <= mag_total_reg + TOTW'(bin_in.bin_mag);
                if (bin_count_reg == CW'(1) ||
                    (bin_count_reg >= CW'(2) && bin_in.bin_mag > peak_mag_reg))
                begin
                    peak_mag_reg  <= bin_in.bin_mag;
                    peak_freq_reg <= bin_in.bin_freq;
                end
            end
            if (p_vld_reg)
            begin
                weighted_reg <= weighted_reg + WW'(p_mf_reg);
                if (p_inb_reg)
                begin
                    if (band_power_reg > {ENERGY_W{1'b1}} - ENERGY_W'(p_sq_reg))
                        band_power_reg <= {ENERGY_W{1'b1}};
                    else
                        band_power_reg <= band_power_reg + ENERGY_W'(p_sq_reg);
                end
            end
            if (cmd.clear)
            begin
                bin_count_reg  <= '0;
                mag_total_reg  <= '0;
                weighted_reg   <= '0;
                band_power_reg <= '0;
                peak_mag_reg   <= '0;
                peak_freq_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_sq_reg  <= bin_in.bin_mag * bin_in.bin_mag;
        p_mf_reg  <= bin_in.bin_mag * bin_in.bin_freq;
        p_inb_reg <= (bin_in.bin_freq >= band_low_reg) && (bin_in.bin_freq < band_high_reg);
    end

    // restoring divider, one quotient bit per cycle; quotient fits in FREQ_W bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.div_start)
            dcnt_reg <= DCW'(QW);
        else if (cmd.div_step && dcnt_reg != '0)
            dcnt_reg <= dcnt_reg - DCW'(1);
    end

    // shift dividend bits in MSB first: remainder starts with the top part
    logic [WW-1:0] dvd_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= WW'(weighted_reg >> QW);
            dvd_reg <= weighted_reg << (WW - QW);
            quo_reg <= '0;
        end
        else if (cmd.div_step && dcnt_reg != '0)
        begin
            if ({rem_reg, dvd_reg[WW-1]} >= {1'b0, {FREQ_W{1'b0}}, mag_total_reg})
            begin
                rem_reg <= WW'({rem_reg, dvd_reg[WW-1]} - {1'b0, {FREQ_W{1'b0}}, mag_total_reg});
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= WW'({rem_reg, dvd_reg[WW-1]});
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
            dvd_reg <= dvd_reg << 1;
        end
    end
    assign stat.div_done = (dcnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raddr_reg <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            raddr_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_rd)
                raddr_reg <= raddr_reg + AW'(1);
            if (cmd.scan_acc && !found_reg && (TW'(run_next) << FRAC_W) >= target_reg)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            run_reg    <= '0;
            target_reg <= TW'(roll_fraction_reg) * TW'(mag_total_reg);
            roll_reg   <= '0;
        end
        else if (cmd.scan_acc && !found_reg)
        begin
            run_reg  <= run_next;
            roll_reg <= rfreq_reg;
        end
    end

    assign stat.scan_hit = found_reg;
    assign stat.scan_end = (raddr_reg == last_addr) || (bin_count_reg == CW'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result.centroid_freq <= (mag_total_reg == '0) ? '0 : quo_reg;
            result.rolloff_freq  <= (bin_count_reg == '0) ? '0 : roll_reg;
            result.dominant_freq <= (bin_count_reg < CW'(2)) ? '0 : peak_freq_reg;
            result.band_energy   <= band_power_reg;
            result.too_few_bins  <= bin_count_reg < CW'(2);
        end
    end
endmodule

// ===== sv/sfe_ctrl.sv =====
`timescale 1ns / 1ps
module sfe_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           last_bin,
    input  sfe_pkg::stat_t stat,
    output sfe_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           done
);
    import sfe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SETTLE, S_LOAD, S_DIV, S_SCAN_RD, S_SCAN_ACC, S_EMIT, S_OUT
    } state_t;

    state_t state_reg;
    logic   busy_reg, done_reg, scan_last_reg;

    // S_SETTLE lets the product stage fold the last bin into the sums
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:     cmd.take = start;
            S_SETTLE:   cmd.scan_start = 1'b1;
            S_LOAD:     cmd.div_start = 1'b1;
            S_DIV:      cmd.div_step = 1'b1;
            S_SCAN_RD:  cmd.scan_rd = 1'b1;
            S_SCAN_ACC: cmd.scan_acc = 1'b1;
            S_EMIT:     cmd.emit = 1'b1;
            S_OUT:      cmd.clear = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            scan_last_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (start && last_bin)
                    begin
                        state_reg <= S_SETTLE;
                        busy_reg  <= 1'b1;
                    end
                    else if (start)
                        busy_reg <= 1'b0;
                S_SETTLE: state_reg <= S_LOAD;
                S_LOAD:   state_reg <= S_DIV;
                S_DIV:
                    if (stat.div_done)
                        state_reg <= S_SCAN_RD;
                S_SCAN_RD:
                begin
                    scan_last_reg <= stat.scan_end;
                    state_reg     <= S_SCAN_ACC;
                end
                S_SCAN_ACC:
                    if (scan_last_reg)
                        state_reg <= S_EMIT;
                    else
                        state_reg <= S_SCAN_RD;
                S_EMIT:
                begin
                    state_reg <= S_OUT;
                    done_reg  <= 1'b1;
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
endmodule

// ===== sv/sfe_checker.sv =====
`timescale 1ns / 1ps
`include "spectral_feature_extractor_assert.svh"
module sfe_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input sfe_pkg::bin_t bin_in,
    input sfe_pkg::result_t result
);
    `SFE_ASSERT_NEXT(a_last_busy, clk, rst_n, start && !busy && bin_in.last_bin, busy)
    `SFE_ASSERT_IMPL(a_done_busy, clk, rst_n, done, busy)
    `SFE_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `SFE_ASSERT_IMPL(a_few_dom, clk, rst_n, done && result.too_few_bins, result.dominant_freq == '0)
endmodule

bind spectral_feature_extractor sfe_checker u_chk (
    .clk, .rst_n, .start, .busy, .done, .bin_in, .result
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import sfe_pkg::*;

    localparam int NBINS = 4096;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam logic [MAG_W-1:0] MAG_MAX = '1;
    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
    localparam logic [ENERGY_W-1:0] ENERGY_SAT = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    bin_t bin_in = '0;
    logic done;
    result_t result;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    spectral_feature_extractor DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .bin_in(bin_in),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // predictor state
    logic [FRAC_W-1:0] roll_frac = ROLL_FRACTION_RST;
    logic [FREQ_W-1:0] lo_edge = BAND_LOW_RST;
    logic [FREQ_W-1:0] hi_edge = BAND_HIGH_RST;
    logic [MAG_W-1:0] mag_mem [NBINS];
    logic [FREQ_W-1:0] freq_mem [NBINS];
    int unsigned nbins = 0;
    logic [35:0] sum_mag = '0;
    logic [54:0] sum_weighted = '0;
    logic [ENERGY_W-1:0] energy = '0;
    logic [MAG_W-1:0] top_mag = '0;
    logic [FREQ_W-1:0] top_freq = '0;

    bin_t bin_queue [$];
    result_t feature_queue [$];
    int unsigned idle_pct = 0;
    bit beat_taken = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned errors = 0;

    task automatic predict_bin(input bin_t b);
        logic [47:0] sq;
        logic [63:0] target, run;
        result_t r;
        bit found;
        if (nbins < NBINS) begin
            mag_mem[nbins] = b.bin_mag;
            freq_mem[nbins] = b.bin_freq;
            sum_mag += b.bin_mag;
            sum_weighted += 55'(b.bin_mag) * 55'(b.bin_freq);
            if (b.bin_freq >= lo_edge && b.bin_freq < hi_edge) begin
                sq = 48'(b.bin_mag) * 48'(b.bin_mag);
                if (energy > ENERGY_SAT - 60'(sq)) energy = ENERGY_SAT;
                else energy += 60'(sq);
            end
            if (nbins == 1 || (nbins >= 2 && b.bin_mag > top_mag)) begin
                top_mag = b.bin_mag;
                top_freq = b.bin_freq;
            end
            nbins++;
        end
        if (b.last_bin) begin
            r.centroid_freq = (sum_mag == 0) ? '0 : FREQ_W'(sum_weighted / 55'(sum_mag));
            target = 64'(roll_frac) * 64'(sum_mag);
            run = '0;
            found = 1'b0;
            r.rolloff_freq = (nbins == 0) ? '0 : freq_mem[nbins-1];
            for (int i = 0; i < nbins && !found; i++) begin
                run += mag_mem[i];
                if ((run << 16) >= target) begin
                    r.rolloff_freq = freq_mem[i];
                    found = 1'b1;
                end
            end
            r.too_few_bins = (nbins < 2);
            r.dominant_freq = r.too_few_bins ? '0 : top_freq;
            r.band_energy = energy;
            feature_queue.push_back(r);
            nbins = 0;
            sum_mag = '0;
            sum_weighted = '0;
            energy = '0;
            top_mag = '0;
            top_freq = '0;
        end
    endtask

    // monitor: check results, take accepted beats
    always @(posedge clk) begin
        if (rst_n) begin
            quiet_cycles = quiet_cycles + 1;
            if (done) begin
                quiet_cycles = 0;
                if (feature_queue.size() == 0) begin
                    $error("unexpected result beat");
                    errors++;
                end else begin
                    result_t e;
                    e = feature_queue.pop_front();
                    if (result.centroid_freq !== e.centroid_freq) begin
                        $error("centroid_freq exp %0d got %0d", e.centroid_freq,
                               result.centroid_freq);
                        errors++;
                    end
                    if (result.rolloff_freq !== e.rolloff_freq) begin
                        $error("rolloff_freq exp %0d got %0d", e.rolloff_freq,
                               result.rolloff_freq);
                        errors++;
                    end
                    if (result.dominant_freq !== e.dominant_freq) begin
                        $error("dominant_freq exp %0d got %0d", e.dominant_freq,
                               result.dominant_freq);
                        errors++;
                    end
                    if (result.band_energy !== e.band_energy) begin
                        $error("band_energy exp %0d got %0d", e.band_energy,
                               result.band_energy);
                        errors++;
                    end
                    if (result.too_few_bins !== e.too_few_bins) begin
                        $error("too_few_bins exp %0d got %0d", e.too_few_bins,
                               result.too_few_bins);
                        errors++;
                    end
                end
            end
            if (start && !busy) begin
                quiet_cycles = 0;
                predict_bin(bin_in);
                void'(bin_queue.pop_front());
                beat_taken = 1'b1;
            end
            if (cfg_we) quiet_cycles = 0;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // driver: start stays up until the beat is taken
    always @(negedge clk) begin
        if (!(start && !beat_taken)) begin
            if (bin_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                start <= 1'b1;
                bin_in <= bin_queue[0];
            end else begin
                start <= 1'b0;
            end
        end
        beat_taken = 1'b0;
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ROLL_FRACTION: roll_frac = val[FRAC_W-1:0];
            REG_BAND_LOW:      lo_edge = val;
            REG_BAND_HIGH:     hi_edge = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (bin_queue.size() == 0 && feature_queue.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic push_bin(input logic [FREQ_W-1:0] f, input logic [MAG_W-1:0] m,
                            input bit last);
        bin_t b;
        b.bin_freq = f;
        b.bin_mag = m;
        b.last_bin = last;
        bin_queue.push_back(b);
    endtask

    // mode: 0 random, 1 all zero, 2 all max, 3 small values
    task automatic push_spectrum(input int n, input int mode);
        logic [MAG_W-1:0] m;
        for (int i = 0; i < n; i++) begin
            case (mode)
                1: m = '0;
                2: m = MAG_MAX;
                3: m = MAG_W'($urandom_range(0, 7));
                default: m = MAG_W'($urandom_range(0, 32'hFFFFFF));
            endcase
            push_bin(FREQ_W'($urandom_range(0, 524287)), m, i == n - 1);
        end
    endtask

    task automatic random_config();
        case ($urandom_range(0, 3))
            0: write_reg(REG_ROLL_FRACTION, '0);
            1: write_reg(REG_ROLL_FRACTION, CFG_W'(16'hFFFF));
            default: write_reg(REG_ROLL_FRACTION, CFG_W'($urandom_range(0, 65535)));
        endcase
        write_reg(REG_BAND_LOW, CFG_W'($urandom_range(0, 300000)));
        write_reg(REG_BAND_HIGH, CFG_W'($urandom_range(100000, 524287)));
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed
        push_bin(FREQ_MAX, MAG_MAX, 1'b1);           // single bin
        push_spectrum(3, 1);                          // zero magnitude sum
        push_spectrum(3, 2);                          // max magnitudes, tie for peak
        push_bin('0, '0, 1'b0);
        push_bin(FREQ_MAX, 24'd5, 1'b0);
        push_bin(19'd1000, 24'd5, 1'b1);              // tie: earliest wins
        push_bin(19'd10, MAG_MAX, 1'b0);              // bin 0 largest, skipped
        push_bin(19'd20, 24'd1, 1'b1);
        drain();
        write_reg(REG_ROLL_FRACTION, '0);
        write_reg(REG_BAND_LOW, CFG_W'(19'd400000));
        write_reg(REG_BAND_HIGH, CFG_W'(19'd1000));   // inverted band
        push_spectrum(4, 0);
        push_spectrum(2, 3);
        drain();
        write_reg(REG_ROLL_FRACTION, CFG_W'(16'hFFFF));
        write_reg(REG_BAND_LOW, CFG_W'(19'd5000));
        write_reg(REG_BAND_HIGH, CFG_W'(19'd5000));   // empty band
        push_spectrum(5, 0);
        drain();

        // random phases with different sender idling
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 47;
                2: idle_pct = 0;
                default: idle_pct = 37;
            endcase
            random_config();
            for (int s = 0; s < 13; s++)
                push_spectrum($urandom_range(1, 12), ($urandom_range(0, 9) == 0) ? 3 :
                              ($urandom_range(0, 19) == 0) ? 1 :
                              ($urandom_range(0, 19) == 0) ? 2 : 0);
            drain();
        end

        // longer spectrum of max magnitudes over the full band
        idle_pct = 0;
        write_reg(REG_BAND_LOW, '0);
        write_reg(REG_BAND_HIGH, CFG_W'(FREQ_MAX));
        push_spectrum(40, 2);
        drain();

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/sfe_pkg.sv
sv/sfe_datapath.sv
sv/sfe_ctrl.sv
sv/spectral_feature_extractor.sv
sv/sfe_checker.sv
tb/testbench.sv
